// ===== rtl/rfsc_pkg.sv =====
// Package for the free-space ray counter: map geometry, request codes,
// queue entry and result types. Used by every file under rtl but rfsc_ram.
package rfsc_pkg;

  localparam int MAP_COLS = 256;
  localparam int MAP_ROWS = 256;
  localparam int COL_W = $clog2(MAP_COLS);
  localparam int ROW_W = $clog2(MAP_ROWS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH = MAP_COLS * MAP_ROWS;
  // ray coordinates: 8-bit origin plus 10-bit signed offset, plus step room
  localparam int CRD_W = 13;
  localparam int ERR_W = 14;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [16:0] WORK_MAX = 17'h1FFFF;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    REQ_LOAD_OBS = 3'd0,
    REQ_LOAD_CNT = 3'd1,
    REQ_TRACE    = 3'd2,
    REQ_COMMIT   = 3'd3,
    REQ_READ     = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    REG_ORIGIN_COL = 2'd0,
    REG_ORIGIN_ROW = 2'd1,
    REG_OBS_CODE   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ_WAIT, ST_TR_CHECK, ST_TR_STEP, ST_TR_OBS, ST_TR_MARK,
    ST_CM_RD, ST_CM_WAIT, ST_CM_WR, ST_CLR, ST_DONE
  } be_state_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0] kind;
    logic on_map;
    logic [ADDR_W-1:0] addr;
    logic [15:0] data;
    logic signed [CRD_W-1:0] sc;
    logic signed [CRD_W-1:0] sr;
    logic signed [CRD_W-1:0] ec;
    logic signed [CRD_W-1:0] er;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic hit;
    logic [7:0] hit_col;
    logic [7:0] hit_row;
    logic [16:0] work;
  } res_t;

  function automatic logic crd_on_map(logic signed [CRD_W-1:0] c,
                                      logic signed [CRD_W-1:0] r);
    return c >= 0 && c < MAP_COLS && r >= 0 && r < MAP_ROWS;
  endfunction

  function automatic logic [ADDR_W-1:0] crd_addr(logic signed [CRD_W-1:0] c,
                                                 logic signed [CRD_W-1:0] r);
    return {r[ROW_W-1:0], c[COL_W-1:0]};
  endfunction

endpackage

// ===== rtl/rfsc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module rfsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rfsc_front.sv =====
// Front end: accepts request beats, forms ray endpoints and map addresses,
// and pushes classified items into a short queue. Uses rfsc_pkg.
module rfsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          req_type,
  input  logic [7:0]          pix_col,
  input  logic [7:0]          pix_row,
  input  logic [15:0]         pix_data,
  input  logic signed [9:0]   start_off_col,
  input  logic signed [9:0]   start_off_row,
  input  logic signed [9:0]   end_off_col,
  input  logic signed [9:0]   end_off_row,
  input  logic [7:0]          origin_col,
  input  logic [7:0]          origin_row,
  output logic                q_valid,
  input  logic                q_pop,
  output rfsc_pkg::item_t     q_item
);
  rfsc_pkg::item_t q [rfsc_pkg::QDEPTH];
  logic [1:0] cnt;
  logic rp, wp;
  rfsc_pkg::item_t it;
  logic push;

  // classify the incoming beat
  always_comb begin
    it = '0;
    it.kind = req_type;
    it.on_map = (32'(pix_col) < rfsc_pkg::MAP_COLS) && (32'(pix_row) < rfsc_pkg::MAP_ROWS);
    it.addr = rfsc_pkg::ADDR_W'({pix_row, pix_col});
    it.data = pix_data;
    it.sc = $signed({5'd0, origin_col}) + rfsc_pkg::CRD_W'(start_off_col);
    it.sr = $signed({5'd0, origin_row}) + rfsc_pkg::CRD_W'(start_off_row);
    it.ec = $signed({5'd0, origin_col}) + rfsc_pkg::CRD_W'(end_off_col);
    it.er = $signed({5'd0, origin_row}) + rfsc_pkg::CRD_W'(end_off_row);
  end

  assign in_ready = cnt != 2'(rfsc_pkg::QDEPTH);
  assign push = in_valid && in_ready;
  assign q_valid = cnt != 2'd0;
  assign q_item = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= it;
    if (rst) begin
      cnt <= '0;
      rp <= 1'b0;
      wp <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// ===== rtl/rfsc_back.sv =====
// Back end: sequencer that executes loads, reads, ray traces and commits
// against the map RAMs. Uses rfsc_pkg and rfsc_ram.
module rfsc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      obstacle_code,
  input  logic            q_valid,
  output logic            q_pop,
  input  rfsc_pkg::item_t q_item,
  output logic            res_valid,
  input  logic            res_ready,
  output rfsc_pkg::res_t  res
);
  localparam int AW = rfsc_pkg::ADDR_W;
  localparam int CW = rfsc_pkg::CRD_W;

  rfsc_pkg::be_state_t state, state_next;
  rfsc_pkg::item_t cur;
  logic signed [CW-1:0] c, r, lc, lr;
  logic signed [rfsc_pkg::ERR_W-1:0] err;
  logic [CW-1:0] dc, dr;
  logic [CW:0] n;
  logic [AW:0] sweep;
  rfsc_pkg::res_t acc;

  // RAM ports
  logic obs_we, cnt_we, vis_we;
  logic [AW-1:0] obs_wa, obs_ra, cnt_wa, cnt_ra, vis_wa, vis_ra;
  logic [7:0] obs_wd, obs_rd;
  logic [15:0] cnt_wd, cnt_rd;
  logic vis_wd, vis_rd;
  logic clr_done;

  rfsc_ram #(.WIDTH(8), .DEPTH(rfsc_pkg::DEPTH)) u_obs (
    .clk, .we(obs_we), .waddr(obs_wa), .wdata(obs_wd), .raddr(obs_ra), .rdata(obs_rd));
  rfsc_ram #(.WIDTH(16), .DEPTH(rfsc_pkg::DEPTH)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
  rfsc_ram #(.WIDTH(1), .DEPTH(rfsc_pkg::DEPTH)) u_vis (
    .clk, .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd));

  logic signed [CW-1:0] nc, nr;
  logic step_col;
  logic [AW-1:0] sw_a;
  assign sw_a = sweep[AW-1:0];
  assign step_col = err > 0;
  always_comb begin
    nc = step_col ? (cur.ec > cur.sc ? c + CW'(1) : c - CW'(1)) : c;
    nr = step_col ? r : (cur.er > cur.sr ? r + CW'(1) : r - CW'(1));
  end
  assign clr_done = sweep == (AW+1)'(rfsc_pkg::DEPTH);

  // state register and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfsc_pkg::ST_CLR;
      sweep <= '0;
    end else begin
      state <= state_next;
      case (state)
        rfsc_pkg::ST_CLR: sweep <= sweep + 1'b1;
        rfsc_pkg::ST_IDLE: sweep <= '0;
        rfsc_pkg::ST_CM_WR: sweep <= sweep + 1'b1;
        default: ;
      endcase
    end
    case (state)
      rfsc_pkg::ST_IDLE: begin
        cur <= q_item;
        acc <= '0;
        c <= q_item.sc;
        r <= q_item.sr;
        dc <= q_item.ec > q_item.sc ? q_item.ec - q_item.sc : q_item.sc - q_item.ec;
        dr <= q_item.er > q_item.sr ? q_item.er - q_item.sr : q_item.sr - q_item.er;
        err <= rfsc_pkg::ERR_W'(
          (q_item.ec > q_item.sc ? q_item.ec - q_item.sc : q_item.sc - q_item.ec)) -
          rfsc_pkg::ERR_W'(
          (q_item.er > q_item.sr ? q_item.er - q_item.sr : q_item.sr - q_item.er));
      end
      rfsc_pkg::ST_READ_WAIT:
        if (cur.on_map) acc.read_data <= cnt_rd;
      rfsc_pkg::ST_TR_CHECK: n <= (CW+1)'(dc) + (CW+1)'(dr) + 1'b1;
      rfsc_pkg::ST_TR_STEP: begin
        lc <= c;
        lr <= r;
        c <= nc;
        r <= nr;
        n <= n - 1'b1;
        if (step_col) err <= err - rfsc_pkg::ERR_W'({dr, 1'b0});
        else err <= err + rfsc_pkg::ERR_W'({dc, 1'b0});
      end
      rfsc_pkg::ST_TR_OBS:
        if (rfsc_pkg::crd_on_map(c, r) && obs_rd == obstacle_code) begin
          acc.hit <= 1'b1;
          acc.hit_col <= c[7:0];
          acc.hit_row <= r[7:0];
        end
      rfsc_pkg::ST_TR_MARK:
        if (!(lc == cur.ec && lr == cur.er) && !vis_rd) acc.work <= acc.work + 1'b1;
      rfsc_pkg::ST_CM_WR:
        if (vis_rd && cnt_rd != rfsc_pkg::COUNT_MAX && acc.work != rfsc_pkg::WORK_MAX)
          acc.work <= acc.work + 1'b1;
      default: ;
    endcase
  end

  // next state and RAM control
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    res_valid = 1'b0;
    obs_we = 1'b0; obs_wa = cur.addr; obs_wd = cur.data[7:0];
    obs_ra = rfsc_pkg::crd_addr(c, r);
    cnt_we = 1'b0; cnt_wa = cur.addr; cnt_wd = cur.data;
    cnt_ra = cur.addr;
    vis_we = 1'b0; vis_wa = rfsc_pkg::crd_addr(lc, lr); vis_wd = 1'b1;
    vis_ra = rfsc_pkg::crd_addr(lc, lr);
    case (state)
      rfsc_pkg::ST_CLR: begin
        vis_we = 1'b1; vis_wa = sw_a; vis_wd = 1'b0;
        if (sweep == (AW+1)'(rfsc_pkg::DEPTH - 1)) state_next = rfsc_pkg::ST_IDLE;
      end
      rfsc_pkg::ST_IDLE:
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.kind)
            rfsc_pkg::REQ_LOAD_OBS: begin
              obs_we = q_item.on_map; obs_wa = q_item.addr; obs_wd = q_item.data[7:0];
              state_next = rfsc_pkg::ST_DONE;
            end
            rfsc_pkg::REQ_LOAD_CNT: begin
              cnt_we = q_item.on_map; cnt_wa = q_item.addr; cnt_wd = q_item.data;
              state_next = rfsc_pkg::ST_DONE;
            end
            rfsc_pkg::REQ_READ: begin
              cnt_ra = q_item.addr;
              state_next = rfsc_pkg::ST_READ_WAIT;
            end
            rfsc_pkg::REQ_TRACE: state_next = rfsc_pkg::ST_TR_CHECK;
            rfsc_pkg::REQ_COMMIT: state_next = rfsc_pkg::ST_CM_RD;
            default: state_next = rfsc_pkg::ST_DONE;
          endcase
        end
      rfsc_pkg::ST_READ_WAIT: state_next = rfsc_pkg::ST_DONE;
      rfsc_pkg::ST_TR_CHECK: state_next = rfsc_pkg::ST_TR_STEP;
      rfsc_pkg::ST_TR_STEP: begin
        // loop ends when n runs out or the current pixel is off the map
        if (n == '0 || !rfsc_pkg::crd_on_map(c, r)) state_next = rfsc_pkg::ST_DONE;
        else begin
          obs_ra = rfsc_pkg::crd_addr(nc, nr);
          vis_ra = rfsc_pkg::crd_addr(c, r);
          state_next = rfsc_pkg::ST_TR_OBS;
        end
      end
      rfsc_pkg::ST_TR_OBS: begin
        if (rfsc_pkg::crd_on_map(c, r) && obs_rd == obstacle_code)
          state_next = rfsc_pkg::ST_DONE;
        else state_next = rfsc_pkg::ST_TR_MARK;
      end
      rfsc_pkg::ST_TR_MARK: begin
        vis_we = !(lc == cur.ec && lr == cur.er);
        state_next = rfsc_pkg::ST_TR_STEP;
      end
      rfsc_pkg::ST_CM_RD: begin
        cnt_ra = sw_a; vis_ra = sw_a;
        state_next = rfsc_pkg::ST_CM_WAIT;
      end
      // hold the sweep address so the read data stays on this pixel
      rfsc_pkg::ST_CM_WAIT: begin
        cnt_ra = sw_a; vis_ra = sw_a;
        state_next = rfsc_pkg::ST_CM_WR;
      end
      rfsc_pkg::ST_CM_WR: begin
        cnt_we = vis_rd && cnt_rd != rfsc_pkg::COUNT_MAX;
        cnt_wa = sw_a; cnt_wd = cnt_rd + 16'd1;
        vis_we = vis_rd; vis_wa = sw_a; vis_wd = 1'b0;
        if (sweep == (AW+1)'(rfsc_pkg::DEPTH - 1)) state_next = rfsc_pkg::ST_DONE;
        else state_next = rfsc_pkg::ST_CM_RD;
      end
      rfsc_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = rfsc_pkg::ST_IDLE;
      end
      default: state_next = rfsc_pkg::ST_IDLE;
    endcase
  end

  assign res = acc;

  // hit location stays zero on every result beat without a hit
  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.hit |-> res.hit_col == 8'd0 && res.hit_row == 8'd0)
    else $error("hit location set without hit");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == rfsc_pkg::ST_IDLE && q_valid)
    else $error("queue popped outside idle");
  a_clr_end: assert property (@(posedge clk) disable iff (rst)
    state == rfsc_pkg::ST_CLR |-> !clr_done)
    else $error("clearing pass overran");
endmodule

// ===== rtl/rfsc_out.sv =====
// Output skid register: holds one finished result beat so the back end
// can continue. Uses rfsc_pkg.
module rfsc_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  output logic           res_ready,
  input  rfsc_pkg::res_t res,
  output logic           out_valid,
  input  logic           out_ready,
  output rfsc_pkg::res_t out_res
);
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res <= res;
    if (rst) out_valid <= 1'b0;
    else if (res_ready) out_valid <= res_valid;
  end
endmodule

// ===== rtl/ray_free_space_count_update.sv =====
// Free-space ray counter over a 256 x 256 map. Each request beat yields one
// result beat. A trace walks the ray pixel by pixel through the step, obstacle
// check and mark states of the stepper; a commit sweeps every map pixel of the
// visited bitmap and count RAM through read, wait and write states. After reset
// a clearing pass zeroes the visited bitmap; up to two beats are queued during
// it but none runs. The user must write registers only while no beat is in
// flight; the block itself does not enforce this.
module ray_free_space_count_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic [7:0]         pix_col,
  input  logic [7:0]         pix_row,
  input  logic [15:0]        pix_data,
  input  logic signed [9:0]  start_off_col,
  input  logic signed [9:0]  start_off_row,
  input  logic signed [9:0]  end_off_col,
  input  logic signed [9:0]  end_off_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        read_data,
  output logic               hit_obstacle,
  output logic [7:0]         hit_col,
  output logic [7:0]         hit_row,
  output logic [16:0]        work_count
);
  logic [7:0] origin_col, origin_row, obstacle_code;
  logic q_valid, q_pop, res_valid, res_ready;
  rfsc_pkg::item_t q_item;
  rfsc_pkg::res_t res, out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_col <= 8'd0;
      origin_row <= 8'd0;
      obstacle_code <= 8'd254;
    end else if (cfg_we) begin
      case (cfg_index)
        rfsc_pkg::REG_ORIGIN_COL: origin_col <= cfg_data;
        rfsc_pkg::REG_ORIGIN_ROW: origin_row <= cfg_data;
        rfsc_pkg::REG_OBS_CODE: obstacle_code <= cfg_data;
        default: ;
      endcase
    end
  end

  rfsc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .pix_col, .pix_row, .pix_data,
    .start_off_col, .start_off_row, .end_off_col, .end_off_row,
    .origin_col, .origin_row, .q_valid, .q_pop, .q_item);

  rfsc_back u_back (
    .clk, .rst, .obstacle_code, .q_valid, .q_pop, .q_item,
    .res_valid, .res_ready, .res);

  rfsc_out u_out (
    .clk, .rst, .res_valid, .res_ready, .res, .out_valid, .out_ready, .out_res);

  assign read_data = out_res.read_data;
  assign hit_obstacle = out_res.hit;
  assign hit_col = out_res.hit_col;
  assign hit_row = out_res.hit_row;
  assign work_count = out_res.work;
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for ray_free_space_count_update: directed table, then random traffic.
// A behavioral predictor of the maps and ray stepper checks each beat the table does not fix.
// Depends on rtl/rfsc_pkg.sv and rtl/ray_free_space_count_update.sv.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
  localparam int NPIX = rfsc_pkg::MAP_COLS * rfsc_pkg::MAP_ROWS;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] col;
    logic [7:0] row;
    logic [15:0] data;
    logic signed [9:0] soc;
    logic signed [9:0] sor;
    logic signed [9:0] eoc;
    logic signed [9:0] eor;
    bit known;
    rfsc_pkg::res_t want;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] req_type = '0;
  logic [7:0] pix_col = '0;
  logic [7:0] pix_row = '0;
  logic [15:0] pix_data = '0;
  logic signed [9:0] start_off_col = '0;
  logic signed [9:0] start_off_row = '0;
  logic signed [9:0] end_off_col = '0;
  logic signed [9:0] end_off_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] read_data;
  logic hit_obstacle;
  logic [7:0] hit_col;
  logic [7:0] hit_row;
  logic [16:0] work_count;

  // predictor state
  logic [7:0] obs_map [NPIX];
  logic [15:0] cnt_map [NPIX];
  bit visited [NPIX];
  bit obs_written [NPIX];
  bit cnt_written [NPIX];
  logic [7:0] org_col = 8'd0;
  logic [7:0] org_row = 8'd0;
  logic [7:0] obs_code = 8'd254;

  rfsc_pkg::res_t result_q [$];
  beat_t dir_tab [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  ray_free_space_count_update dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("** ray_free_space_count_update: FAILED **");
    $finish;
  end

  function automatic bit on_map(int c, int r);
    return c >= 0 && c < rfsc_pkg::MAP_COLS && r >= 0 && r < rfsc_pkg::MAP_ROWS;
  endfunction

  // Walks one ray. With apply clear nothing changes; safe tells whether the
  // walk only touches map entries that have been written.
  function automatic rfsc_pkg::res_t walk_ray(beat_t b, bit apply, output bit safe);
    rfsc_pkg::res_t res;
    int sc, sr, ec, er, dc, dr, n, cs, rs, err, c, r, lc, lr, a;
    res = '0;
    safe = 1;
    sc = int'(org_col) + int'(b.soc);
    sr = int'(org_row) + int'(b.sor);
    ec = int'(org_col) + int'(b.eoc);
    er = int'(org_row) + int'(b.eor);
    dc = ec > sc ? ec - sc : sc - ec;
    dr = er > sr ? er - sr : sr - er;
    n = 1 + dc + dr;
    cs = ec > sc ? 1 : -1;
    rs = er > sr ? 1 : -1;
    err = dc - dr;
    c = sc;
    r = sr;
    for (; n > 0; n--) begin
      if (!on_map(c, r)) break;
      lc = c;
      lr = r;
      if (err > 0) begin
        c += cs;
        err -= 2 * dr;
      end else begin
        r += rs;
        err += 2 * dc;
      end
      if (on_map(c, r)) begin
        a = r * rfsc_pkg::MAP_COLS + c;
        if (!obs_written[a]) safe = 0;
        if (obs_map[a] == obs_code) begin
          res.hit = 1'b1;
          res.hit_col = c[7:0];
          res.hit_row = r[7:0];
          break;
        end
      end
      if (lc == ec && lr == er) continue;
      a = lr * rfsc_pkg::MAP_COLS + lc;
      if (!cnt_written[a]) safe = 0;
      if (!visited[a]) begin
        if (apply) visited[a] = 1;
        res.work++;
      end
    end
    return res;
  endfunction

  // Expected result of one accepted request; updates the predictor state.
  function automatic rfsc_pkg::res_t predict_result(beat_t b);
    rfsc_pkg::res_t res;
    int a;
    bit ok;
    res = '0;
    a = int'(b.row) * rfsc_pkg::MAP_COLS + int'(b.col);
    case (b.kind)
      rfsc_pkg::REQ_LOAD_OBS: begin
        obs_map[a] = b.data[7:0];
        obs_written[a] = 1;
      end
      rfsc_pkg::REQ_LOAD_CNT: begin
        cnt_map[a] = b.data;
        cnt_written[a] = 1;
      end
      rfsc_pkg::REQ_READ: res.read_data = cnt_map[a];
      rfsc_pkg::REQ_TRACE: res = walk_ray(b, 1'b1, ok);
      rfsc_pkg::REQ_COMMIT: begin
        for (int i = 0; i < NPIX; i++) begin
          if (visited[i]) begin
            if (cnt_map[i] < rfsc_pkg::COUNT_MAX) begin
              cnt_map[i]++;
              if (res.work < rfsc_pkg::WORK_MAX) res.work++;
            end
            visited[i] = 0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic beat_t mk(logic [2:0] kind, int c, int r, int d,
                               int soc, int sor, int eoc, int eor);
    beat_t b;
    b.kind = kind;
    b.col = c[7:0];
    b.row = r[7:0];
    b.data = d[15:0];
    b.soc = soc[9:0];
    b.sor = sor[9:0];
    b.eoc = eoc[9:0];
    b.eor = eor[9:0];
    b.known = 0;
    b.want = '0;
    return b;
  endfunction

  function automatic beat_t mk_known(beat_t b, rfsc_pkg::res_t want);
    b.known = 1;
    b.want = want;
    return b;
  endfunction

  function automatic void add_row(beat_t b);
    dir_tab.insert(dir_tab.size(), b);
  endfunction

  // one request beat; the expectation is queued at acceptance
  task automatic send_beat(beat_t b);
    rfsc_pkg::res_t p;
    in_valid <= 1'b1;
    req_type <= b.kind;
    pix_col <= b.col;
    pix_row <= b.row;
    pix_data <= b.data;
    start_off_col <= b.soc;
    start_off_row <= b.sor;
    end_off_col <= b.eoc;
    end_off_row <= b.eor;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_result(b);
    result_q.insert(result_q.size(), b.known ? b.want : p);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(rfsc_pkg::reg_idx_t idx, logic [7:0] val);
    drain();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rfsc_pkg::REG_ORIGIN_COL: org_col = val;
      rfsc_pkg::REG_ORIGIN_ROW: org_row = val;
      default: obs_code = val;
    endcase
  endtask

  // pixel inside one of the two fully loaded corner windows
  function automatic int win_px(bit hi);
    return hi ? $urandom_range(rfsc_pkg::MAP_COLS - 8, rfsc_pkg::MAP_COLS - 1)
              : $urandom_range(0, 7);
  endfunction

  function automatic beat_t random_ray();
    beat_t b;
    bit ok, hi;
    int sc, sr;
    for (int t = 0; t < 40; t++) begin
      hi = 1'($urandom_range(1));
      sc = win_px(hi);
      sr = win_px(hi);
      b = mk(rfsc_pkg::REQ_TRACE, 0, 0, 0, sc - int'(org_col), sr - int'(org_row), 0, 0);
      if ($urandom_range(99) < 8) begin
        b.soc = 10'($urandom);
        b.sor = 10'($urandom);
      end
      if ($urandom_range(99) < 60) begin
        b.eoc = 10'(sc + int'($urandom_range(0, 6)) - 3 - int'(org_col));
        b.eor = 10'(sr + int'($urandom_range(0, 6)) - 3 - int'(org_row));
      end else begin
        b.eoc = 10'($urandom);
        b.eor = 10'($urandom);
      end
      void'(walk_ray(b, 1'b0, ok));
      if (ok) return b;
    end
    // start equals end on row 0: the only step leaves the map
    sc = win_px(1'b0);
    return mk(rfsc_pkg::REQ_TRACE, 0, 0, 0, sc - int'(org_col), -int'(org_row),
              sc - int'(org_col), -int'(org_row));
  endfunction

  function automatic beat_t random_beat();
    int pick, c, r;
    bit hi;
    pick = $urandom_range(99);
    hi = 1'($urandom_range(1));
    c = win_px(hi);
    r = win_px(hi);
    if (pick < 50) return random_ray();
    if (pick < 62) return mk(rfsc_pkg::REQ_LOAD_OBS, c, r, $urandom, 0, 0, 0, 0);
    if (pick < 74) return mk(rfsc_pkg::REQ_LOAD_CNT, c, r, $urandom, 0, 0, 0, 0);
    if (pick < 95) return mk(rfsc_pkg::REQ_READ, c, r, $urandom, $urandom, $urandom, 0, 0);
    return mk(REQ_BAD_FIRST + 3'($urandom_range(0, 2)), $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_beat(random_beat());
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin : rx_side
    bit rdy;
    if (hold_req) begin
      hold_req = 0;
      hold_left <= HOLD_CYCLES;
      rdy = 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rdy = 0;
    end else begin
      rdy = $urandom_range(99) >= stall_pct;
    end
    out_ready <= rdy;
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : rx_check
    rfsc_pkg::res_t w;
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %0h/%0b/%0h/%0h/%0h",
                 $time, read_data, hit_obstacle, hit_col, hit_row, work_count);
        errors++;
      end else begin
        w = result_q.pop_front();
        check_field("read_data", 32'(w.read_data), 32'(read_data));
        check_field("hit_obstacle", 32'(w.hit), 32'(hit_obstacle));
        check_field("hit_col", 32'(w.hit_col), 32'(hit_col));
        check_field("hit_row", 32'(w.hit_row), 32'(hit_row));
        check_field("work_count", 32'(w.work), 32'(work_count));
      end
    end
  end

  initial begin : stim
    int vals [6];
    int waited;
    vals = '{0, 254, 255, 77, 1, 0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table, reset configuration
    add_row(mk(rfsc_pkg::REQ_LOAD_OBS, 0, 0, 16'h0000, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_LOAD_OBS, 1, 0, 16'hABFE, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_LOAD_OBS, 0, 1, 16'hFF00, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_LOAD_OBS, 0, 2, 16'h0000, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_LOAD_OBS, 0, 3, 16'h0000, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_LOAD_OBS, 255, 255, 16'h0000, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_LOAD_CNT, 0, 0, 16'hFFFF, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_LOAD_CNT, 0, 1, 16'hFFFE, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_LOAD_CNT, 0, 2, 16'h0000, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_LOAD_CNT, 255, 255, 16'h5A5A, 0, 0, 0, 0));
    add_row(mk_known(mk(rfsc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0),
                     '{16'hFFFF, 1'b0, 8'd0, 8'd0, 17'd0}));
    add_row(mk_known(mk(rfsc_pkg::REQ_READ, 255, 255, 16'hFFFF, 0, 0, 0, 0),
                     '{16'h5A5A, 1'b0, 8'd0, 8'd0, 17'd0}));
    for (int k = 0; k < 3; k++)
      add_row(mk_known(mk(REQ_BAD_FIRST + 3'(k), 255, 255, 16'hFFFF, 511, 511, -512,
                          -512), '0));
    // start off the map: nothing walked
    add_row(mk_known(mk(rfsc_pkg::REQ_TRACE, 0, 0, 0, -512, -512, 511, 511), '0));
    // first step lands on the obstacle
    add_row(mk_known(mk(rfsc_pkg::REQ_TRACE, 0, 0, 0, 0, 0, 3, 0),
                     '{16'h0, 1'b1, 8'd1, 8'd0, 17'd0}));
    // vertical ray, end pixel not marked, step past the end tested
    add_row(mk(rfsc_pkg::REQ_TRACE, 0, 0, 0, 0, 0, 0, 2));
    // corner pixel, next step leaves the map and counts as free
    add_row(mk(rfsc_pkg::REQ_TRACE, 0, 0, 0, 255, 255, 511, 511));
    // saturating commit
    add_row(mk(rfsc_pkg::REQ_COMMIT, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_READ, 0, 1, 0, 0, 0, 0, 0));
    add_row(mk(rfsc_pkg::REQ_READ, 255, 255, 0, 0, 0, 0, 0));
    foreach (dir_tab[i]) send_beat(dir_tab[i]);

    // load both corner windows completely
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        for (int hi = 0; hi < 2; hi++) begin
          send_beat(mk(rfsc_pkg::REQ_LOAD_OBS, hi * (rfsc_pkg::MAP_COLS - 8) + c,
                       hi * (rfsc_pkg::MAP_ROWS - 8) + r,
                       $urandom_range(99) < 50 ? vals[$urandom_range(0, 4)] : $urandom,
                       0, 0, 0, 0));
          send_beat(mk(rfsc_pkg::REQ_LOAD_CNT, hi * (rfsc_pkg::MAP_COLS - 8) + c,
                       hi * (rfsc_pkg::MAP_ROWS - 8) + r,
                       $urandom_range(99) < 20 ? 16'hFFFE + $urandom_range(1) : $urandom,
                       0, 0, 0, 0));
        end

    // no idling
    write_reg(rfsc_pkg::REG_ORIGIN_COL, 8'd255);
    write_reg(rfsc_pkg::REG_ORIGIN_ROW, 8'd255);
    write_reg(rfsc_pkg::REG_OBS_CODE, 8'd0);
    random_phase(200);
    send_beat(mk(rfsc_pkg::REQ_COMMIT, 0, 0, 0, 0, 0, 0, 0));

    // sender mostly idle, then a long receiver hold-off
    write_reg(rfsc_pkg::REG_ORIGIN_COL, 8'd0);
    write_reg(rfsc_pkg::REG_ORIGIN_ROW, 8'd0);
    write_reg(rfsc_pkg::REG_OBS_CODE, 8'd255);
    idle_pct = 79;
    random_phase(200);
    idle_pct = 0;
    hold_req = 1;
    random_phase(12);

    // receiver mostly stalled
    write_reg(rfsc_pkg::REG_ORIGIN_COL, 8'd128);
    write_reg(rfsc_pkg::REG_ORIGIN_ROW, 8'd7);
    write_reg(rfsc_pkg::REG_OBS_CODE, 8'd254);
    stall_pct = 79;
    random_phase(200);
    send_beat(mk(rfsc_pkg::REQ_COMMIT, 0, 0, 0, 0, 0, 0, 0));

    // both sides idle now and then, with one full pause
    write_reg(rfsc_pkg::REG_ORIGIN_COL, 8'd6);
    write_reg(rfsc_pkg::REG_ORIGIN_ROW, 8'd250);
    write_reg(rfsc_pkg::REG_OBS_CODE, 8'd77);
    idle_pct = 24;
    stall_pct = 24;
    random_phase(92);
    drain();
    random_phase(92);

    // wind down
    in_valid <= 1'b0;
    waited = 0;
    while (result_q.size() != 0 && waited < 500_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("** ray_free_space_count_update: PASSED **");
    end else begin
      $display("** ray_free_space_count_update: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rfsc_pkg.sv
rtl/rfsc_ram.sv
rtl/rfsc_front.sv
rtl/rfsc_back.sv
rtl/rfsc_out.sv
rtl/ray_free_space_count_update.sv
bench/tb_top.sv
